### rtl/lai12eu_pkg.sv
// ----------------------------------------------------------------------------
// lai12eu_pkg
// shared types, constants and codes of the i12 execute unit
// ----------------------------------------------------------------------------
package lai12eu_pkg;

  localparam int unsigned XLEN      = 32;
  localparam int unsigned NUM_REGS  = 32;
  localparam int unsigned REG_IDX_W = $clog2(NUM_REGS);
  localparam int unsigned IMM_W     = 12;
  localparam int unsigned OP_W      = 3;

  // instruction word field positions
  localparam int unsigned RD_LSB  = 0;
  localparam int unsigned RJ_LSB  = 5;
  localparam int unsigned IMM_LSB = 10;

  // data memory: byte addressed, power-of-two size, split into four byte lanes
  localparam int unsigned MEM_BYTES = 4096;
  localparam int unsigned LANES     = 4;
  localparam int unsigned LANE_W    = $clog2(LANES);
  localparam int unsigned MEM_IDX_W = $clog2(MEM_BYTES);
  localparam int unsigned MEM_ROWS  = MEM_BYTES / LANES;
  localparam int unsigned ROW_W     = MEM_IDX_W - LANE_W;

  typedef enum logic [OP_W-1:0] {
    OP_ORI   = 3'd0,
    OP_ADDI  = 3'd1,
    OP_ANDI  = 3'd2,
    OP_STB   = 3'd3,
    OP_LDB   = 3'd4,
    OP_LDW   = 3'd5,
    OP_STW   = 3'd6,
    OP_SLTUI = 3'd7
  } op_e;

  // register file read request (two read ports)
  typedef struct packed {
    logic                 re;
    logic [REG_IDX_W-1:0] addr_j;
    logic [REG_IDX_W-1:0] addr_d;
  } rf_rd_t;

  // register file write request
  typedef struct packed {
    logic                 we;
    logic [REG_IDX_W-1:0] addr;
    logic [XLEN-1:0]      data;
  } rf_wr_t;

  // data memory request, one row across all byte lanes
  typedef struct packed {
    logic             re;
    logic [LANES-1:0] we;
    logic [ROW_W-1:0] row;
    logic [XLEN-1:0]  wdata;
  } dm_req_t;

endpackage

### rtl/lai12eu_in_if.sv
// ----------------------------------------------------------------------------
// lai12eu_in_if
// instruction channel: operation selector and instruction word
// ----------------------------------------------------------------------------
interface lai12eu_in_if;
  logic                              valid;
  logic                              ready;
  logic [lai12eu_pkg::OP_W-1:0]      operation;
  logic [lai12eu_pkg::XLEN-1:0]      instruction_word;

  modport source (output valid, output operation, output instruction_word, input ready);
  modport sink   (input valid, input operation, input instruction_word, output ready);
endinterface

### rtl/lai12eu_out_if.sv
// ----------------------------------------------------------------------------
// lai12eu_out_if
// result channel: register write-back and memory access report
// ----------------------------------------------------------------------------
interface lai12eu_out_if;
  logic                                valid;
  logic                                ready;
  logic                                reg_write;
  logic [lai12eu_pkg::REG_IDX_W-1:0]   reg_index;
  logic [lai12eu_pkg::XLEN-1:0]        reg_value;
  logic                                mem_store;
  logic [lai12eu_pkg::XLEN-1:0]        mem_address;
  logic [lai12eu_pkg::XLEN-1:0]        mem_data;
  logic                                mem_size;

  modport source (output valid, output reg_write, output reg_index, output reg_value,
                  output mem_store, output mem_address, output mem_data, output mem_size,
                  input ready);
  modport sink   (input valid, input reg_write, input reg_index, input reg_value,
                  input mem_store, input mem_address, input mem_data, input mem_size,
                  output ready);
endinterface

### rtl/lai12eu_regfile.sv
// ----------------------------------------------------------------------------
// lai12eu_regfile
// 32 x 32 register file, two synchronous read ports, one write port
// ----------------------------------------------------------------------------
module lai12eu_regfile (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  lai12eu_pkg::rf_rd_t                   rd_req_i,
  input  lai12eu_pkg::rf_wr_t                   wr_req_i,
  output logic [lai12eu_pkg::XLEN-1:0]          rj_data_o,
  output logic [lai12eu_pkg::XLEN-1:0]          rd_data_o
);

  logic [lai12eu_pkg::XLEN-1:0]     mem_q [lai12eu_pkg::NUM_REGS];
  logic [lai12eu_pkg::NUM_REGS-1:0] valid_q;
  logic [lai12eu_pkg::XLEN-1:0]     rj_next, rd_next;

  // entries not yet written read as zero; same-edge write is passed through
  always_comb begin
    if (wr_req_i.we && wr_req_i.addr == rd_req_i.addr_j) begin
      rj_next = wr_req_i.data;
    end else if (valid_q[rd_req_i.addr_j]) begin
      rj_next = mem_q[rd_req_i.addr_j];
    end else begin
      rj_next = '0;
    end
    if (wr_req_i.we && wr_req_i.addr == rd_req_i.addr_d) begin
      rd_next = wr_req_i.data;
    end else if (valid_q[rd_req_i.addr_d]) begin
      rd_next = mem_q[rd_req_i.addr_d];
    end else begin
      rd_next = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_req_i.we) begin
      valid_q[wr_req_i.addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_req_i.we) begin
      mem_q[wr_req_i.addr] <= wr_req_i.data;
    end
    if (rd_req_i.re) begin
      rj_data_o <= rj_next;
      rd_data_o <= rd_next;
    end
  end

endmodule

### rtl/lai12eu_dmem.sv
// ----------------------------------------------------------------------------
// lai12eu_dmem
// byte memory as four byte lanes, one row read or written per cycle
// ----------------------------------------------------------------------------
module lai12eu_dmem (
  input  logic                          clk_i,
  input  lai12eu_pkg::dm_req_t          req_i,
  output logic [lai12eu_pkg::XLEN-1:0]  rdata_o
);

  for (genvar l = 0; l < lai12eu_pkg::LANES; l++) begin : g_lane
    logic [7:0] lane_q [lai12eu_pkg::MEM_ROWS];
    logic [7:0] rdata_q;

    always_ff @(posedge clk_i) begin
      if (req_i.we[l]) begin
        lane_q[req_i.row] <= req_i.wdata[8*l +: 8];
      end
      if (req_i.re) begin
        rdata_q <= lane_q[req_i.row];
      end
    end

    assign rdata_o[8*l +: 8] = rdata_q;
  end

endmodule

### rtl/loongarch_i12_execute_unit_core.sv
// ----------------------------------------------------------------------------
// loongarch_i12_execute_unit_core
// executes one LoongArch32 12-bit-immediate instruction per transfer
// stages in order: register read, execute / memory issue, write-back
// throughput: one instruction per cycle while result_o.ready does not hold the pipeline, set by the
//   single register file write port and the one-row-per-cycle data memory
// reset: register file reads as zero (per-entry valid bits), pipeline empty;
//   data memory content is undefined until stored
// ----------------------------------------------------------------------------
module loongarch_i12_execute_unit_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  lai12eu_in_if.sink     item_i,
  lai12eu_out_if.source  result_o
);

  localparam int unsigned XLEN = lai12eu_pkg::XLEN;

  // --------------------------------------------------------------------------
  // pipeline control
  // --------------------------------------------------------------------------
  logic out_v_q, s1_v_q, s2_v_q;
  logic out_ready, s2_ready, s1_ready;
  logic in_xfer, s1_adv, s2_adv;

  assign out_ready = !out_v_q || result_o.ready;
  assign s2_ready  = !s2_v_q || out_ready;
  assign s1_ready  = !s1_v_q || s2_ready;
  assign in_xfer   = item_i.valid && s1_ready;
  assign s1_adv    = s1_v_q && s2_ready;
  assign s2_adv    = s2_v_q && out_ready;

  assign item_i.ready = s1_ready;

  // --------------------------------------------------------------------------
  // stage 0: decode register indexes and start register file reads
  // --------------------------------------------------------------------------
  lai12eu_pkg::rf_rd_t rf_rd;
  lai12eu_pkg::rf_wr_t rf_wr;
  logic [XLEN-1:0]     rf_rj_data, rf_rd_data;

  assign rf_rd.re     = in_xfer;
  assign rf_rd.addr_j = item_i.instruction_word[lai12eu_pkg::RJ_LSB +: lai12eu_pkg::REG_IDX_W];
  assign rf_rd.addr_d = item_i.instruction_word[lai12eu_pkg::RD_LSB +: lai12eu_pkg::REG_IDX_W];

  lai12eu_regfile u_regfile (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_req_i  (rf_rd),
    .wr_req_i  (rf_wr),
    .rj_data_o (rf_rj_data),
    .rd_data_o (rf_rd_data)
  );

  lai12eu_pkg::op_e                     s1_op_q;
  logic [lai12eu_pkg::REG_IDX_W-1:0]    s1_rj_q, s1_rd_q;
  logic [lai12eu_pkg::IMM_W-1:0]        s1_imm_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (s1_ready) begin
      s1_v_q <= item_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_op_q  <= lai12eu_pkg::op_e'(item_i.operation);
      s1_rj_q  <= rf_rd.addr_j;
      s1_rd_q  <= rf_rd.addr_d;
      s1_imm_q <= item_i.instruction_word[lai12eu_pkg::IMM_LSB +: lai12eu_pkg::IMM_W];
    end
  end

  // --------------------------------------------------------------------------
  // stage 1: operand forwarding, alu, address, store write / load read issue
  // --------------------------------------------------------------------------
  lai12eu_pkg::op_e                     s2_op_q;
  logic [lai12eu_pkg::REG_IDX_W-1:0]    s2_rd_q;
  logic                                 s2_wr_q;
  logic [XLEN-1:0]                      s2_val_q;
  logic [lai12eu_pkg::LANE_W-1:0]       s2_lane_q;
  logic                                 s2_mw_q;
  logic [XLEN-1:0]                      s2_maddr_q;
  logic [XLEN-1:0]                      s2_mdata_q;
  logic                                 s2_msize_q;
  logic [XLEN-1:0]                      s2_wval;

  logic [XLEN-1:0] op_a, op_d, uimm, simm, addr, alu_val, s1_mdata;
  logic            is_load, is_store, is_word, s1_wr;
  logic [lai12eu_pkg::LANES-1:0] st_mask;
  lai12eu_pkg::dm_req_t dm_req;
  logic [XLEN-1:0] dm_rdata;

  // the instruction just ahead may not have written back yet; the one before
  // that is covered by the write-through in the register file read
  assign op_a = (s2_v_q && s2_wr_q && s2_rd_q == s1_rj_q) ? s2_wval : rf_rj_data;
  assign op_d = (s2_v_q && s2_wr_q && s2_rd_q == s1_rd_q) ? s2_wval : rf_rd_data;

  assign uimm = {{(XLEN-lai12eu_pkg::IMM_W){1'b0}}, s1_imm_q};
  assign simm = {{(XLEN-lai12eu_pkg::IMM_W){s1_imm_q[lai12eu_pkg::IMM_W-1]}}, s1_imm_q};
  assign addr = op_a + simm;

  always_comb begin
    is_load  = 1'b0;
    is_store = 1'b0;
    is_word  = 1'b0;
    alu_val  = '0;
    unique case (s1_op_q)
      lai12eu_pkg::OP_ORI:   alu_val = op_a | uimm;
      lai12eu_pkg::OP_ADDI:  alu_val = addr;
      lai12eu_pkg::OP_ANDI:  alu_val = op_a & uimm;
      lai12eu_pkg::OP_STB:   is_store = 1'b1;
      lai12eu_pkg::OP_LDB:   is_load = 1'b1;
      lai12eu_pkg::OP_LDW: begin
        is_load = 1'b1;
        is_word = 1'b1;
      end
      lai12eu_pkg::OP_STW: begin
        is_store = 1'b1;
        is_word  = 1'b1;
      end
      lai12eu_pkg::OP_SLTUI: alu_val = {{(XLEN-1){1'b0}}, op_a < simm};
      default:               alu_val = '0;
    endcase
  end

  // register 0 is never written
  assign s1_wr = !is_store && (s1_rd_q != '0);

  // byte store goes to its lane, word store to all four (word aligned rows)
  assign st_mask  = is_word ? {lai12eu_pkg::LANES{1'b1}}
                            : lai12eu_pkg::LANES'(1) << addr[lai12eu_pkg::LANE_W-1:0];
  assign s1_mdata = is_word ? op_d : {{(XLEN-8){1'b0}}, op_d[7:0]};

  assign dm_req.re    = s1_adv && is_load;
  assign dm_req.we    = (s1_adv && is_store) ? st_mask : '0;
  assign dm_req.row   = addr[lai12eu_pkg::MEM_IDX_W-1:lai12eu_pkg::LANE_W];
  assign dm_req.wdata = is_word ? op_d : {lai12eu_pkg::LANES{op_d[7:0]}};

  lai12eu_dmem u_dmem (
    .clk_i   (clk_i),
    .req_i   (dm_req),
    .rdata_o (dm_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else if (s2_ready) begin
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      s2_op_q    <= s1_op_q;
      s2_rd_q    <= s1_rd_q;
      s2_wr_q    <= s1_wr;
      s2_val_q   <= alu_val;
      s2_lane_q  <= addr[lai12eu_pkg::LANE_W-1:0];
      s2_mw_q    <= is_store;
      s2_maddr_q <= (is_load || is_store) ? addr : '0;
      s2_mdata_q <= is_store ? s1_mdata : '0;
      s2_msize_q <= is_word;
    end
  end

  // --------------------------------------------------------------------------
  // stage 2: load data select, register write-back, result register
  // --------------------------------------------------------------------------
  logic [7:0] ld_byte;

  always_comb begin
    case (s2_lane_q)
      2'd0:    ld_byte = dm_rdata[7:0];
      2'd1:    ld_byte = dm_rdata[15:8];
      2'd2:    ld_byte = dm_rdata[23:16];
      default: ld_byte = dm_rdata[31:24];
    endcase
  end

  always_comb begin
    case (s2_op_q)
      lai12eu_pkg::OP_LDB: s2_wval = {{(XLEN-8){ld_byte[7]}}, ld_byte};
      lai12eu_pkg::OP_LDW: s2_wval = dm_rdata;
      default:             s2_wval = s2_val_q;
    endcase
  end

  assign rf_wr.we   = s2_adv && s2_wr_q;
  assign rf_wr.addr = s2_rd_q;
  assign rf_wr.data = s2_wval;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (out_ready) begin
      out_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_adv) begin
      result_o.reg_write   <= s2_wr_q;
      result_o.reg_index   <= s2_wr_q ? s2_rd_q : '0;
      result_o.reg_value   <= s2_wr_q ? s2_wval : '0;
      result_o.mem_store   <= s2_mw_q;
      result_o.mem_address <= s2_maddr_q;
      result_o.mem_data    <= s2_mdata_q;
      result_o.mem_size    <= s2_msize_q;
    end
  end

  assign result_o.valid = out_v_q;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  a_no_wb_reg0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rf_wr.we |-> rf_wr.addr != '0)
    else $error("write-back to register zero");

  a_store_no_wb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_v_q && s2_mw_q) |-> !s2_wr_q)
    else $error("store marked as register write");

  a_accept_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |-> (!s1_v_q || s1_adv))
    else $error("transfer into occupied stage 1");

  a_wsize_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_v_q && s2_msize_q) |->
      (s2_op_q == lai12eu_pkg::OP_LDW || s2_op_q == lai12eu_pkg::OP_STW))
    else $error("word size on a non-word operation");

  a_wb_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rf_wr.we |=> (out_v_q && result_o.reg_write))
    else $error("register write-back without matching result");

endmodule

### dv/lai12eu_result_checker.sv
// ----------------------------------------------------------------------------
// lai12eu_result_checker
// predicts each result of the i12 execute unit from the instruction
// transfers and compares it field by field with the result transfers
// ----------------------------------------------------------------------------
module lai12eu_result_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  lai12eu_in_if       item_mon,
  lai12eu_out_if      result_mon,
  output int unsigned mismatch_count_o,
  output int unsigned awaiting_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import lai12eu_pkg::*;

  typedef struct packed {
    logic                 reg_write;
    logic [REG_IDX_W-1:0] reg_index;
    logic [XLEN-1:0]      reg_value;
    logic                 mem_store;
    logic [XLEN-1:0]      mem_address;
    logic [XLEN-1:0]      mem_data;
    logic                 mem_size;
  } outcome_t;

  logic [XLEN-1:0] gpr  [NUM_REGS];
  logic [7:0]      dmem [MEM_BYTES];
  outcome_t        expected_outcomes [$];
  int unsigned     mismatches = 0;

  initial begin
    for (int i = 0; i < NUM_REGS; i++) gpr[i] = '0;
    for (int i = 0; i < MEM_BYTES; i++) dmem[i] = '0;
  end

  // architectural effect of one instruction, updates the shadow state
  function automatic outcome_t execute_insn(op_e op, logic [XLEN-1:0] word);
    logic [REG_IDX_W-1:0] rd;
    logic [REG_IDX_W-1:0] rj;
    logic [IMM_W-1:0]     uimm;
    logic [XLEN-1:0]      simm;
    logic [XLEN-1:0]      a;
    logic [XLEN-1:0]      d;
    logic [XLEN-1:0]      addr;
    logic [XLEN-1:0]      wbase;
    logic [XLEN-1:0]      val;
    logic [7:0]           b;
    logic                 wr;
    outcome_t             o;
    rd    = word[RD_LSB +: REG_IDX_W];
    rj    = word[RJ_LSB +: REG_IDX_W];
    uimm  = word[IMM_LSB +: IMM_W];
    simm  = {{(XLEN-IMM_W){uimm[IMM_W-1]}}, uimm};
    a     = gpr[rj];
    d     = gpr[rd];
    addr  = a + simm;
    wbase = {addr[XLEN-1:2], 2'b00};
    val   = '0;
    wr    = 1'b0;
    o     = '0;
    case (op)
      OP_ORI: begin
        wr  = 1'b1;
        val = a | {{(XLEN-IMM_W){1'b0}}, uimm};
      end
      OP_ADDI: begin
        wr  = 1'b1;
        val = a + simm;
      end
      OP_ANDI: begin
        wr  = 1'b1;
        val = a & {{(XLEN-IMM_W){1'b0}}, uimm};
      end
      OP_STB: begin
        o.mem_store   = 1'b1;
        o.mem_address = addr;
        o.mem_data    = {24'b0, d[7:0]};
        dmem[addr[MEM_IDX_W-1:0]] = d[7:0];
      end
      OP_LDB: begin
        wr            = 1'b1;
        o.mem_address = addr;
        b             = dmem[addr[MEM_IDX_W-1:0]];
        val           = {{24{b[7]}}, b};
      end
      OP_LDW: begin
        wr            = 1'b1;
        o.mem_address = addr;
        o.mem_size    = 1'b1;
        for (int i = 0; i < 4; i++) val[8*i +: 8] = dmem[MEM_IDX_W'(wbase + i)];
      end
      OP_STW: begin
        o.mem_store   = 1'b1;
        o.mem_address = addr;
        o.mem_data    = d;
        o.mem_size    = 1'b1;
        for (int i = 0; i < 4; i++) dmem[MEM_IDX_W'(wbase + i)] = d[8*i +: 8];
      end
      default: begin
        wr  = 1'b1;
        val = (a < simm) ? 32'd1 : 32'd0;
      end
    endcase
    // writes to r0 vanish
    if (wr && rd != '0) begin
      gpr[rd]     = val;
      o.reg_write = 1'b1;
      o.reg_index = rd;
      o.reg_value = val;
    end
    return o;
  endfunction

  function automatic void check_field(string field, logic [XLEN-1:0] want,
                                      logic [XLEN-1:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %h, actual %h", $time, field, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i) begin
    outcome_t want;
    if (rst_ni) begin
      if (item_mon.valid && item_mon.ready)
        expected_outcomes.push_back(execute_insn(op_e'(item_mon.operation),
                                                 item_mon.instruction_word));
      if (result_mon.valid && result_mon.ready) begin
        if (expected_outcomes.size() == 0) begin
          $display("%0t ns: unexpected result, expected none, actual reg %b/%0d/%h mem %b/%h/%h/%b",
                   $time, result_mon.reg_write, result_mon.reg_index, result_mon.reg_value,
                   result_mon.mem_store, result_mon.mem_address, result_mon.mem_data,
                   result_mon.mem_size);
          mismatches++;
        end else begin
          want = expected_outcomes.pop_front();
          check_field("reg_write",   XLEN'(want.reg_write),   XLEN'(result_mon.reg_write));
          check_field("reg_index",   XLEN'(want.reg_index),   XLEN'(result_mon.reg_index));
          check_field("reg_value",   want.reg_value,          result_mon.reg_value);
          check_field("mem_store",   XLEN'(want.mem_store),   XLEN'(result_mon.mem_store));
          check_field("mem_address", want.mem_address,        result_mon.mem_address);
          check_field("mem_data",    want.mem_data,           result_mon.mem_data);
          check_field("mem_size",    XLEN'(want.mem_size),    XLEN'(result_mon.mem_size));
        end
      end
    end
    mismatch_count_o <= mismatches;
    awaiting_o       <= expected_outcomes.size();
  end

endmodule

### dv/loongarch_i12_execute_unit_core_tb.sv
// ----------------------------------------------------------------------------
// loongarch_i12_execute_unit_core_tb
// drives directed and random i12 instructions with random gaps on both
// channels; loads are aimed only at bytes already stored, the result
// checker predicts and compares every result
// ----------------------------------------------------------------------------
module loongarch_i12_execute_unit_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lai12eu_pkg::*;

  localparam int unsigned ITEM_COUNT   = 1100;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned RUN_LIMIT_NS = 600_000;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  lai12eu_in_if  item_if ();
  lai12eu_out_if result_if ();

  int unsigned mismatch_count;
  int unsigned awaiting;

  // stimulus side view of the machine: which registers hold a known value,
  // and which memory bytes have been stored, so loads never touch garbage
  bit                   reg_known    [NUM_REGS];
  logic [XLEN-1:0]      reg_shadow   [NUM_REGS];
  bit                   byte_written [MEM_BYTES];
  logic [MEM_IDX_W-1:0] stored_bytes [$];
  logic [MEM_IDX_W-1:0] stored_words [$];
  bit                   send_burst;
  bit                   drain_burst;

  always #1 clk_i = ~clk_i;

  loongarch_i12_execute_unit_core dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_if),
    .result_o (result_if)
  );

  lai12eu_result_checker outcome_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .item_mon         (item_if),
    .result_mon       (result_if),
    .mismatch_count_o (mismatch_count),
    .awaiting_o       (awaiting)
  );

  // ignored upper bits, imm12, rj, rd
  function automatic logic [XLEN-1:0] make_word(logic [9:0] upper, logic [IMM_W-1:0] imm,
                                                logic [REG_IDX_W-1:0] rj,
                                                logic [REG_IDX_W-1:0] rd);
    return {upper, imm, rj, rd};
  endfunction

  // mostly a few low registers so back-to-back dependencies are common
  function automatic logic [REG_IDX_W-1:0] pick_reg();
    if ($urandom_range(0, 9) < 7) return REG_IDX_W'($urandom_range(0, 7));
    return REG_IDX_W'($urandom_range(0, NUM_REGS-1));
  endfunction

  function automatic logic [REG_IDX_W-1:0] pick_known_reg();
    logic [REG_IDX_W-1:0] r;
    for (int i = 0; i < 8; i++) begin
      r = pick_reg();
      if (reg_known[r]) return r;
    end
    return '0;
  endfunction

  // immediate with its sign and zero-extension boundaries weighted up
  function automatic logic [IMM_W-1:0] pick_imm();
    case ($urandom_range(0, 11))
      0:       return 12'h000;
      1:       return 12'h7FF;
      2:       return 12'h800;
      3:       return 12'hFFF;
      default: return IMM_W'($urandom());
    endcase
  endfunction

  // a stored byte, and the aligned word once all four of its bytes are set
  function automatic void mark_byte(logic [MEM_IDX_W-1:0] idx);
    logic [MEM_IDX_W-1:0] base;
    byte_written[idx] = 1'b1;
    stored_bytes.push_back(idx);
    base = {idx[MEM_IDX_W-1:2], 2'b00};
    if (byte_written[base] && byte_written[base+1] && byte_written[base+2] &&
        byte_written[base+3])
      stored_words.push_back(base);
  endfunction

  // follow what an issued instruction does to the known registers and memory
  function automatic void track_issue(op_e op, logic [XLEN-1:0] word);
    logic [REG_IDX_W-1:0] rd;
    logic [REG_IDX_W-1:0] rj;
    logic [IMM_W-1:0]     uimm;
    logic [XLEN-1:0]      simm;
    logic [XLEN-1:0]      a;
    logic [XLEN-1:0]      addr;
    logic [XLEN-1:0]      v;
    rd   = word[RD_LSB +: REG_IDX_W];
    rj   = word[RJ_LSB +: REG_IDX_W];
    uimm = word[IMM_LSB +: IMM_W];
    simm = {{(XLEN-IMM_W){uimm[IMM_W-1]}}, uimm};
    a    = reg_shadow[rj];
    addr = a + simm;
    v    = '0;
    case (op)
      OP_ORI:   v = a | {{(XLEN-IMM_W){1'b0}}, uimm};
      OP_ADDI:  v = a + simm;
      OP_ANDI:  v = a & {{(XLEN-IMM_W){1'b0}}, uimm};
      OP_SLTUI: v = (a < simm) ? 32'd1 : 32'd0;
      default:  v = '0;
    endcase
    case (op)
      OP_ORI, OP_ADDI, OP_ANDI, OP_SLTUI: begin
        if (rd != '0) begin
          reg_known[rd]  = reg_known[rj];
          reg_shadow[rd] = v;
        end
      end
      OP_LDB, OP_LDW: begin
        // loaded values are not followed here
        if (rd != '0) reg_known[rd] = 1'b0;
      end
      OP_STB: begin
        if (reg_known[rj]) mark_byte(addr[MEM_IDX_W-1:0]);
      end
      default: begin
        if (reg_known[rj])
          for (int i = 0; i < 4; i++)
            mark_byte(MEM_IDX_W'({addr[MEM_IDX_W-1:2], 2'b00} + i));
      end
    endcase
  endfunction

  // random instruction: alu noise, stores anywhere, loads aimed at stored bytes
  function automatic void build_random(output op_e op, output logic [XLEN-1:0] word);
    int unsigned          kind;
    int unsigned          depth;
    int unsigned          k;
    logic [REG_IDX_W-1:0] rj;
    logic [REG_IDX_W-1:0] rd;
    logic [IMM_W-1:0]     imm;
    logic [MEM_IDX_W-1:0] target;
    kind = $urandom_range(0, 99);
    rd   = pick_reg();
    rj   = pick_reg();
    imm  = pick_imm();
    op   = OP_ORI;
    // nothing stored yet, so store instead of loading
    if (kind >= 65 && stored_bytes.size() == 0) kind = 40;
    if (kind < 35) begin
      case ($urandom_range(0, 3))
        0:       op = OP_ORI;
        1:       op = OP_ADDI;
        2:       op = OP_ANDI;
        default: op = OP_SLTUI;
      endcase
    end else if (kind < 65) begin
      op = $urandom_range(0, 1) ? OP_STB : OP_STW;
      if ($urandom_range(0, 4) != 0) rj = pick_known_reg();
    end else begin
      rj = pick_known_reg();
      if (stored_words.size() != 0 && $urandom_range(0, 1)) begin
        op    = OP_LDW;
        depth = stored_words.size();
      end else begin
        op    = OP_LDB;
        depth = stored_bytes.size();
      end
      // once more than four are stored, half the loads go for the latest stores to stress forwarding
      if (depth > 4 && $urandom_range(0, 1)) k = depth - 1 - $urandom_range(0, 3);
      else k = $urandom_range(0, depth - 1);
      if (op == OP_LDW) target = stored_words[k] | MEM_IDX_W'($urandom_range(0, 3));
      else target = stored_bytes[k];
      // the low bits of rj plus imm land on the target whatever rj holds
      imm = IMM_W'(target - reg_shadow[rj][MEM_IDX_W-1:0]);
    end
    word = make_word(10'($urandom()), imm, rj, rd);
  endfunction

  // one instruction transfer after a random gap
  task automatic send_insn(op_e op, logic [XLEN-1:0] word);
    int unsigned gap;
    gap = send_burst ? 0 : $urandom_range(0, 19);
    if (gap != 0) begin
      item_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    item_if.valid            <= 1'b1;
    item_if.operation        <= op;
    item_if.instruction_word <= word;
    @(posedge clk_i);
    while (!item_if.ready) @(posedge clk_i);
    track_issue(op, word);
  endtask

  // result side: random stall before each result, bursts with none
  initial begin : result_drain
    int unsigned hold;
    int unsigned drained;
    result_if.ready <= 1'b0;
    drained = 0;
    wait (rst_ni);
    forever begin
      if (drained % 64 == 0) drain_burst = ($urandom_range(0, 3) == 0);
      hold = drain_burst ? 0 : $urandom_range(0, 19);
      if (hold != 0) begin
        result_if.ready <= 1'b0;
        repeat (hold) @(posedge clk_i);
      end
      result_if.ready <= 1'b1;
      do @(posedge clk_i); while (!result_if.valid);
      drained++;
    end
  end

  initial begin : stimulus
    op_e             op;
    logic [XLEN-1:0] word;
    item_if.valid            <= 1'b0;
    item_if.operation        <= OP_ORI;
    item_if.instruction_word <= '0;
    for (int i = 0; i < NUM_REGS; i++) begin
      reg_known[i]  = 1'b1;
      reg_shadow[i] = '0;
    end
    send_burst = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // immediate extremes: zero-extended max, sign-extended min and max
    send_insn(OP_ORI,   make_word(10'h3FF, 12'hFFF, 5'd0, 5'd1));
    send_insn(OP_ADDI,  make_word(10'h000, 12'h800, 5'd0, 5'd2));
    send_insn(OP_ADDI,  make_word(10'h3FF, 12'h7FF, 5'd0, 5'd3));
    send_insn(OP_ADDI,  make_word(10'h000, 12'hFFF, 5'd0, 5'd4));
    send_insn(OP_ANDI,  make_word(10'h3FF, 12'hFFF, 5'd4, 5'd5));
    send_insn(OP_ANDI,  make_word(10'h000, 12'h000, 5'd4, 5'd5));
    // write to r0 is dropped
    send_insn(OP_ORI,   make_word(10'h3FF, 12'h123, 5'd1, 5'd0));
    // unsigned compare against sign-extended immediate
    send_insn(OP_SLTUI, make_word(10'h000, 12'h800, 5'd1, 5'd6));
    send_insn(OP_SLTUI, make_word(10'h3FF, 12'hFFF, 5'd4, 5'd7));
    send_insn(OP_SLTUI, make_word(10'h000, 12'h001, 5'd0, 5'd7));
    send_insn(OP_SLTUI, make_word(10'h3FF, 12'h800, 5'd0, 5'd0));
    // unaligned word store at the top of the address space lands on the top aligned word
    send_insn(OP_STW,   make_word(10'h000, 12'h000, 5'd4, 5'd2));
    send_insn(OP_LDW,   make_word(10'h3FF, 12'hFFC, 5'd0, 5'd8));
    // byte store and negative byte load through a negative offset
    send_insn(OP_STB,   make_word(10'h000, 12'h7FF, 5'd3, 5'd1));
    send_insn(OP_LDB,   make_word(10'h3FF, 12'hFFF, 5'd4, 5'd9));
    // positive byte
    send_insn(OP_ORI,   make_word(10'h000, 12'h07F, 5'd0, 5'd10));
    send_insn(OP_STB,   make_word(10'h3FF, 12'h010, 5'd0, 5'd10));
    send_insn(OP_LDB,   make_word(10'h000, 12'h010, 5'd0, 5'd11));
    // load into r0 still reports its address
    send_insn(OP_STW,   make_word(10'h3FF, 12'h7FC, 5'd0, 5'd4));
    send_insn(OP_LDW,   make_word(10'h000, 12'h7FC, 5'd0, 5'd0));
    // 32-bit add wrap to zero, then word load with low address bits set
    send_insn(OP_ADDI,  make_word(10'h3FF, 12'h001, 5'd4, 5'd12));
    send_insn(OP_STW,   make_word(10'h000, 12'h000, 5'd12, 5'd3));
    send_insn(OP_LDW,   make_word(10'h3FF, 12'h003, 5'd0, 5'd13));

    for (int unsigned n = 0; n < ITEM_COUNT; n++) begin
      if (n % 64 == 0) send_burst = ($urandom_range(0, 3) == 0);
      build_random(op, word);
      send_insn(op, word);
    end
    item_if.valid <= 1'b0;

    // drain everything in flight, then give stray results time to show up
    do @(posedge clk_i); while (awaiting != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && awaiting == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // hang guard
  initial begin : run_limit
    #(RUN_LIMIT_NS);
    $display("tb: failure");
    $finish;
  end

endmodule

### sim.f
rtl/lai12eu_pkg.sv
rtl/lai12eu_in_if.sv
rtl/lai12eu_out_if.sv
rtl/lai12eu_regfile.sv
rtl/lai12eu_dmem.sv
rtl/loongarch_i12_execute_unit_core.sv
dv/lai12eu_result_checker.sv
dv/loongarch_i12_execute_unit_core_tb.sv
